[rtl/atclr_pkg.sv]
`timescale 1ns / 1ps

package atclr_pkg;

  // Character codes and fixed string lengths
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] ZERO_CHAR    = 8'd0;
  localparam int unsigned SET_LEN     = 9;
  localparam int unsigned QUERY_LEN   = 6;
  localparam int unsigned OK_LEN      = 8;
  localparam int unsigned ERR_LEN     = 6;
  localparam int unsigned DEFAULT_LEN = 9;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_REPLY = 2'b10
  } state_e;

  // Kind of reply being sent
  typedef enum logic [1:0] {
    RPL_OK,
    RPL_ERR,
    RPL_ID
  } reply_e;

  // "AT+SETID="
  function automatic logic [7:0] set_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h41;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h2B;
      4'd3:    c = 8'h53;
      4'd4:    c = 8'h45;
      4'd5:    c = 8'h54;
      4'd6:    c = 8'h49;
      4'd7:    c = 8'h44;
      4'd8:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "AT+ID?"
  function automatic logic [7:0] query_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h2B;
      3'd3:    c = 8'h49;
      3'd4:    c = 8'h44;
      3'd5:    c = 8'h3F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Success\n"
  function automatic logic [7:0] ok_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h53;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h63;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h73;
      3'd6:    c = 8'h73;
      default: c = NEWLINE_CHAR;
    endcase
    return c;
  endfunction

  // "ERROR\n"
  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      default: c = NEWLINE_CHAR;
    endcase
    return c;
  endfunction

  // "DefaultID"
  function automatic logic [7:0] default_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h44;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h66;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h75;
      4'd5:    c = 8'h6C;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h49;
      4'd8:    c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/at_command_line_responder.sv]
`timescale 1ns / 1ps

// AT command line responder.
// Slave stream: one received character per beat on s_axis_tdata. Characters
// are gathered until a newline; each non-newline beat is taken while idle.
// Master stream: the reply to each completed line, one character per beat,
// with m_axis_tlast on the closing newline. Replies are "Success\n" for
// AT+SETID=<id>, the stored ID plus newline for AT+ID?, else "ERROR\n".
// The ID lives in a two-bank byte memory with a registered read; a new ID
// goes to the spare bank and the banks swap when a set line's newline arrives.
// After the newline beat the reply passes the fetch stage and the output
// register, then one beat per cycle while m_axis_tready is high; a reply is
// 1 to ID_CAPACITY beats. The input is not taken while a reply is being
// fetched. A stall on the master side holds the output register and the
// fetched byte behind it; no beat is lost.
// Reset: the ID reads as "DefaultID" (bank zero, overlaid until that bank
// is first written), line state cleared, output empty. No clearing pass.
module at_command_line_responder #(
  parameter int unsigned ID_CAPACITY   = 64,
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast    // last_byte
);

  localparam int unsigned DEPTH = 2 * ID_CAPACITY;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IDX_W = $clog2(ID_CAPACITY);
  localparam int unsigned CNT_W = $clog2(ID_CAPACITY + 1);
  localparam int unsigned POS_W = $clog2(LINE_CAPACITY + 1);

  // Control state
  atclr_pkg::state_e state_q, state_d;
  atclr_pkg::reply_e kind_q, kind_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              setm_q, setm_d;
  logic              qm_q, qm_d;
  logic              ended_q, ended_d;
  logic              active_q, active_d;
  logic [IDX_W-1:0]  idlen_q, idlen_d;
  logic [IDX_W-1:0]  pend_q, pend_d;
  logic              default_q, default_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  total_q, total_d;

  // Fetch stage and output register
  logic              fvalid_q, fvalid_d;
  logic              fmem_q, fmem_d;
  logic [7:0]        fbyte_q, fbyte_d;
  logic              flast_q, flast_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        odata_q, odata_d;
  logic              olast_q, olast_d;

  // Memory port
  logic [7:0]        id_mem_q [DEPTH];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;

  logic              in_beat, take, fetch;
  logic [AW-1:0]     bank_base, spare_base;
  logic [7:0]        rx;

  assign rx         = s_axis_tdata;
  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign take       = !ovalid_q || m_axis_tready;
  assign bank_base  = active_q ? AW'(ID_CAPACITY) : '0;
  assign spare_base = active_q ? '0 : AW'(ID_CAPACITY);
  assign fetch      = (state_q == atclr_pkg::ST_REPLY) && (cnt_q < total_q) &&
                      (!fvalid_q || take);

  // Line parsing, reply fetch and output hand-over
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    pos_d     = pos_q;
    setm_d    = setm_q;
    qm_d      = qm_q;
    ended_d   = ended_q;
    active_d  = active_q;
    idlen_d   = idlen_q;
    pend_d    = pend_q;
    default_d = default_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    fvalid_d  = fvalid_q;
    fmem_d    = fmem_q;
    fbyte_d   = fbyte_q;
    flast_d   = flast_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    olast_d   = olast_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = spare_base + AW'(pend_q);
    mem_raddr = bank_base + AW'(cnt_q);

    // output register drains, refilled from the fetch stage
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    if (take && fvalid_q) begin
      ovalid_d = 1'b1;
      odata_d  = fmem_q ? rdata_q : fbyte_q;
      olast_d  = flast_q;
      fvalid_d = 1'b0;
    end

    unique case (state_q)
      atclr_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (rx == atclr_pkg::NEWLINE_CHAR) begin
            // line complete: pick the reply
            if (setm_q && pos_q >= POS_W'(atclr_pkg::SET_LEN)) begin
              kind_d   = atclr_pkg::RPL_OK;
              total_d  = CNT_W'(atclr_pkg::OK_LEN);
              active_d = !active_q;
              idlen_d  = pend_q;
            end else if (qm_q && pos_q == POS_W'(atclr_pkg::QUERY_LEN)) begin
              kind_d  = atclr_pkg::RPL_ID;
              total_d = CNT_W'(idlen_q) + CNT_W'(1);
            end else begin
              kind_d  = atclr_pkg::RPL_ERR;
              total_d = CNT_W'(atclr_pkg::ERR_LEN);
            end
            cnt_d   = '0;
            state_d = atclr_pkg::ST_REPLY;
            pos_d   = '0;
            setm_d  = 1'b1;
            qm_d    = 1'b1;
            ended_d = 1'b0;
            pend_d  = '0;
          end else if (!ended_q && pos_q < POS_W'(LINE_CAPACITY)) begin
            if (rx == atclr_pkg::ZERO_CHAR) begin
              ended_d = 1'b1;
            end else begin
              if (pos_q < POS_W'(atclr_pkg::SET_LEN)) begin
                if (rx != atclr_pkg::set_char(pos_q[3:0])) begin
                  setm_d = 1'b0;
                end
              end else if (setm_q && pend_q < IDX_W'(ID_CAPACITY - 1)) begin
                // ID text goes to the spare bank
                mem_we = 1'b1;
                pend_d = pend_q + IDX_W'(1);
                if (active_q) begin
                  default_d = 1'b0;
                end
              end
              if (pos_q < POS_W'(atclr_pkg::QUERY_LEN)) begin
                if (rx != atclr_pkg::query_char(pos_q[2:0])) begin
                  qm_d = 1'b0;
                end
              end
              pos_d = pos_q + POS_W'(1);
            end
          end
        end
      end
      atclr_pkg::ST_REPLY: begin
        if (fetch) begin
          fvalid_d = 1'b1;
          fmem_d   = 1'b0;
          flast_d  = (cnt_q == total_q - CNT_W'(1));
          case (kind_q)
            atclr_pkg::RPL_OK:  fbyte_d = atclr_pkg::ok_char(cnt_q[2:0]);
            atclr_pkg::RPL_ERR: fbyte_d = atclr_pkg::err_char(cnt_q[2:0]);
            default: begin
              if (cnt_q < CNT_W'(idlen_q)) begin
                if (!active_q && default_q &&
                    cnt_q < CNT_W'(atclr_pkg::DEFAULT_LEN)) begin
                  fbyte_d = atclr_pkg::default_char(cnt_q[3:0]);
                end else begin
                  fmem_d = 1'b1;
                  mem_re = 1'b1;
                end
              end else begin
                fbyte_d = atclr_pkg::NEWLINE_CHAR;
              end
            end
          endcase
          cnt_d = cnt_q + CNT_W'(1);
        end else if (cnt_q == total_q && !fvalid_q) begin
          state_d = atclr_pkg::ST_IDLE;
        end
      end
      default: state_d = atclr_pkg::ST_IDLE;
    endcase
  end

  // ID memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      id_mem_q[mem_waddr] <= rx;
    end
    if (mem_re) begin
      rdata_q <= id_mem_q[mem_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= atclr_pkg::ST_IDLE;
      kind_q    <= atclr_pkg::RPL_ERR;
      pos_q     <= '0;
      setm_q    <= 1'b1;
      qm_q      <= 1'b1;
      ended_q   <= 1'b0;
      active_q  <= 1'b0;
      idlen_q   <= IDX_W'(atclr_pkg::DEFAULT_LEN);
      pend_q    <= '0;
      default_q <= 1'b1;
      cnt_q     <= '0;
      total_q   <= '0;
      fvalid_q  <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      pos_q     <= pos_d;
      setm_q    <= setm_d;
      qm_q      <= qm_d;
      ended_q   <= ended_d;
      active_q  <= active_d;
      idlen_q   <= idlen_d;
      pend_q    <= pend_d;
      default_q <= default_d;
      cnt_q     <= cnt_d;
      total_q   <= total_d;
      fvalid_q  <= fvalid_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fmem_q  <= fmem_d;
    fbyte_q <= fbyte_d;
    flast_q <= flast_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign s_axis_tready = (state_q == atclr_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  // Checks
  a_idle_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atclr_pkg::ST_IDLE) |-> !fvalid_q)
    else $error("fetched byte left behind on return to idle");

  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == atclr_pkg::NEWLINE_CHAR))
    else $error("reply does not close with a newline");

  a_port_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("ID memory read and written in one cycle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atclr_pkg::ST_REPLY) |-> (cnt_q <= total_q))
    else $error("reply index beyond reply length");

endmodule

[sim/atclr_reply_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the responder, predicts each reply from the
// received characters and compares every reply beat in order.
module atclr_reply_checker #(
  parameter int unsigned ID_CAPACITY   = 64,
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } reply_beat_t;

  string set_cmd    = "AT+SETID=";
  string query_cmd  = "AT+ID?";
  string ok_text    = "Success\n";
  string err_text   = "ERROR\n";
  string default_id = "DefaultID";

  // Replies still owed by the block, oldest first
  reply_beat_t reply_q[$];
  reply_beat_t want;

  // Mirror of the ID banks and the line parser
  logic [7:0]  id_mem [2*ID_CAPACITY];
  logic        bank_sel;
  logic [6:0]  id_len;
  logic [6:0]  spare_len;
  logic [7:0]  line_pos;
  logic        set_ok;
  logic        query_ok;
  logic        zero_seen;
  int unsigned mismatches = 0;
  int unsigned pending_beats = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_beats;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: reply mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_line();
    line_pos  = '0;
    set_ok    = 1'b1;
    query_ok  = 1'b1;
    zero_seen = 1'b0;
    spare_len = '0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      reply_q.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endtask

  // One received character: update the line state, queue any reply
  task automatic take_rx_char(input logic [7:0] c);
    int unsigned base;
    int unsigned n;
    if (c == atclr_pkg::NEWLINE_CHAR) begin
      if (set_ok && line_pos >= atclr_pkg::SET_LEN) begin
        bank_sel = ~bank_sel;
        id_len   = spare_len;
        push_text(ok_text);
      end else if (query_ok && line_pos == atclr_pkg::QUERY_LEN) begin
        base = bank_sel ? ID_CAPACITY : 0;
        n    = (id_len > ID_CAPACITY - 1) ? ID_CAPACITY - 1 : id_len;
        for (int unsigned k = 0; k < n; k++) begin
          reply_q.push_back('{ch: id_mem[base + k], last: 1'b0});
        end
        reply_q.push_back('{ch: atclr_pkg::NEWLINE_CHAR, last: 1'b1});
      end else begin
        push_text(err_text);
      end
      clear_line();
    end else if (!zero_seen && line_pos < LINE_CAPACITY) begin
      if (c == atclr_pkg::ZERO_CHAR) begin
        zero_seen = 1'b1;
      end else begin
        if (line_pos < atclr_pkg::SET_LEN) begin
          if (c != set_cmd[line_pos]) set_ok = 1'b0;
        end else if (set_ok && spare_len < ID_CAPACITY - 1) begin
          // new ID goes to the bank not currently in use
          base = bank_sel ? 0 : ID_CAPACITY;
          id_mem[base + spare_len] = c;
          spare_len++;
        end
        if (line_pos < atclr_pkg::QUERY_LEN && c != query_cmd[line_pos]) query_ok = 1'b0;
        line_pos++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q.delete();
      for (int i = 0; i < atclr_pkg::DEFAULT_LEN; i++) id_mem[i] = default_id[i];
      bank_sel = 1'b0;
      id_len   = 7'(atclr_pkg::DEFAULT_LEN);
      clear_line();
      pending_beats = 0;
    end else begin
      // reply beat leaving the block
      if (m_tvalid_i && m_tready_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %02h last %b", m_tdata_i, m_tlast_i));
        end else begin
          want = reply_q.pop_front();
          if (m_tdata_i !== want.ch)
            report_mismatch($sformatf("char %02h, wanted %02h", m_tdata_i, want.ch));
          if (m_tlast_i !== want.last)
            report_mismatch($sformatf("tlast %b, wanted %b on char %02h",
                                      m_tlast_i, want.last, want.ch));
        end
      end
      // received character taken by the block
      if (s_tvalid_i && s_tready_i) take_rx_char(s_tdata_i);
      pending_beats = reply_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Sends AT command lines into the responder, both sides idling at random;
// the checker beside the block predicts and compares the replies.
module tb_top;

  localparam int unsigned ID_CAP   = 64;
  localparam int unsigned LINE_CAP = 128;

  typedef enum int {
    LN_QUERY,
    LN_SET,
    LN_SET_LONG,
    LN_QUERY_ZERO,
    LN_SET_ZERO,
    LN_NEAR_MISS,
    LN_SHORT,
    LN_LONG,
    LN_NOISE,
    LN_COUNT
  } line_kind_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  int unsigned mismatches;
  int unsigned pending_beats;

  // calm and hold_req set by the sender; all three read by the receiver
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  string set_cmd   = "AT+SETID=";
  string query_cmd = "AT+ID?";

  logic [7:0] line_q[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  at_command_line_responder #(
    .ID_CAPACITY  (ID_CAP),
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  atclr_reply_checker #(
    .ID_CAPACITY  (ID_CAP),
    .LINE_CAPACITY(LINE_CAP)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .fail_count_o(mismatches),
    .pending_o   (pending_beats)
  );

  // Any text character: never a newline, never zero
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == atclr_pkg::NEWLINE_CHAR);
    return c;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_random_text(input int unsigned n);
    repeat (n) line_q.push_back(text_char());
  endtask

  // One beat on the slave side, with an occasional gap before it
  task automatic put_beat(input logic [7:0] b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic put_line();
    foreach (line_q[i]) put_beat(line_q[i]);
    line_q.delete();
  endtask

  // Fill line_q with one line of the given kind, newline included
  task automatic build_line(input line_kind_e kind);
    int unsigned pos;
    int unsigned target;
    logic [7:0]  c;
    case (kind)
      LN_QUERY: begin
        add_text(query_cmd);
      end
      LN_SET: begin
        add_text(set_cmd);
        add_random_text($urandom_range(0, 12));
      end
      LN_SET_LONG: begin
        add_text(set_cmd);
        add_random_text($urandom_range(ID_CAP - 2, ID_CAP + 6));
      end
      LN_QUERY_ZERO: begin
        add_text(query_cmd);
        line_q.push_back(atclr_pkg::ZERO_CHAR);
        repeat ($urandom_range(0, 4)) begin
          do c = 8'($urandom_range(0, 255)); while (c == atclr_pkg::NEWLINE_CHAR);
          line_q.push_back(c);
        end
      end
      LN_SET_ZERO: begin
        add_text(set_cmd);
        add_random_text($urandom_range(0, 6));
        line_q.push_back(atclr_pkg::ZERO_CHAR);
        add_random_text($urandom_range(0, 5));
      end
      LN_NEAR_MISS: begin
        case ($urandom_range(0, 2))
          0: begin
            // query with trailing characters
            add_text(query_cmd);
            add_random_text($urandom_range(1, 3));
          end
          1: begin
            add_text(query_cmd);
            pos = $urandom_range(0, atclr_pkg::QUERY_LEN - 1);
            do c = text_char(); while (c == line_q[pos]);
            line_q[pos] = c;
          end
          default: begin
            add_text(set_cmd);
            pos = $urandom_range(0, atclr_pkg::SET_LEN - 1);
            do c = text_char(); while (c == line_q[pos]);
            line_q[pos] = c;
            add_random_text($urandom_range(0, 5));
          end
        endcase
      end
      LN_SHORT: begin
        // a head of the set prefix, empty line included
        target = $urandom_range(0, atclr_pkg::SET_LEN - 1);
        for (int i = 0; i < target; i++) line_q.push_back(set_cmd[i]);
      end
      LN_LONG: begin
        case ($urandom_range(0, 2))
          0:       add_text(set_cmd);
          1:       add_text(query_cmd);
          default: ;
        endcase
        target = $urandom_range(LINE_CAP - 4, LINE_CAP + 8);
        add_random_text(target - line_q.size());
      end
      default: begin
        // raw bytes, stray newlines and zeros allowed
        repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    line_q.push_back(atclr_pkg::NEWLINE_CHAR);
  endtask

  // Master side: random stalls, one long hold-off, none at the end
  initial begin
    int unsigned hold_cnt;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    int unsigned guard;
    line_kind_e  kind;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset ID, empty ID and its read-back, byte extremes
    add_text(query_cmd);
    line_q.push_back(atclr_pkg::NEWLINE_CHAR);
    add_text(set_cmd);
    line_q.push_back(atclr_pkg::NEWLINE_CHAR);
    add_text(query_cmd);
    line_q.push_back(atclr_pkg::NEWLINE_CHAR);
    line_q.push_back(8'hFF);
    line_q.push_back(atclr_pkg::ZERO_CHAR);
    line_q.push_back(atclr_pkg::NEWLINE_CHAR);
    put_line();

    // Random: every kind once, then weighted toward well-formed commands
    hold_req = 1'b1;
    sent = 0;
    n    = 0;
    while (n < LN_COUNT || sent < 110) begin
      if (n < LN_COUNT) begin
        kind = line_kind_e'(n);
      end else begin
        r = $urandom_range(0, 99);
        if      (r < 30) kind = LN_QUERY;
        else if (r < 55) kind = LN_SET;
        else if (r < 63) kind = LN_QUERY_ZERO;
        else if (r < 71) kind = LN_SET_ZERO;
        else if (r < 83) kind = LN_NEAR_MISS;
        else if (r < 91) kind = LN_SHORT;
        else if (r < 94) kind = LN_SET_LONG;
        else             kind = LN_NOISE;
      end
      build_line(kind);
      // over-long lines mostly go unread, so they are not counted
      if (kind != LN_LONG && kind != LN_SET_LONG) sent += line_q.size();
      if (sent >= 85) calm = 1'b1;
      put_line();
      n++;
    end
    s_axis_tvalid <= 1'b0;

    // let the checker take the final newline before looking at its backlog
    @(posedge clk_i);
    guard = 0;
    while (pending_beats != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_beats == 0) begin
      $display("PASS at_command_line_responder");
    end else begin
      $display("FAIL at_command_line_responder");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("FAIL at_command_line_responder");
    $finish;
  end

endmodule
